// ----- hdl/lsmc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsmc_pkg
// Shared types and constants for the limit switch motor controller.
// ----------------------------------------------------------------------------
package lsmc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int LIMIT_WIDTH     = 16;
    localparam logic [LIMIT_WIDTH-1:0] RUN_LIMIT_RESET = 16'd6000;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_REV  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_CMD     = 3'd1,
        CAUSE_TOP     = 3'd2,
        CAUSE_BOTTOM  = 3'd3,
        CAUSE_TIMEOUT = 3'd4
    } cause_t;

    typedef enum logic [1:0] {
        REFUSE_NONE   = 2'd0,
        REFUSE_TOP    = 2'd1,
        REFUSE_BOTTOM = 2'd2
    } refuse_t;

    // control state carried from tick to tick (elapsed count kept apart)
    typedef struct packed {
        mode_t run_state;
        mode_t pending_request;
        logic  top_seen;
        logic  bottom_seen;
        logic  timing_on;
    } ctrl_state_t;

    typedef struct packed {
        logic    drive_a;
        logic    drive_b;
        mode_t   motor_mode;
        logic    top_active;
        logic    bottom_active;
        logic    indicator_led;
        cause_t  stop_cause;
        refuse_t refused;
        logic    status_update;
    } result_t;

endpackage

// ----- hdl/lsmc_if.sv -----
// ----------------------------------------------------------------------------
// lsmc_if
// Valid/ready channels for tick words and result words.
// ----------------------------------------------------------------------------
interface lsmc_tick_if;
    logic       valid;
    logic       ready;
    logic       top_switch;
    logic       bottom_switch;
    logic       cmd_valid;
    logic [1:0] cmd_dir;

    modport source (output valid, top_switch, bottom_switch, cmd_valid, cmd_dir,
                    input ready);
    modport sink (input valid, top_switch, bottom_switch, cmd_valid, cmd_dir,
                  output ready);
endinterface

interface lsmc_result_if;
    logic       valid;
    logic       ready;
    logic       drive_a;
    logic       drive_b;
    logic [1:0] motor_mode;
    logic       top_active;
    logic       bottom_active;
    logic       indicator_led;
    logic [2:0] stop_cause;
    logic [1:0] refused;
    logic       status_update;

    modport source (output valid, drive_a, drive_b, motor_mode, top_active,
                    bottom_active, indicator_led, stop_cause, refused,
                    status_update,
                    input ready);
    modport sink (input valid, drive_a, drive_b, motor_mode, top_active,
                  bottom_active, indicator_led, stop_cause, refused,
                  status_update,
                  output ready);
endinterface

// ----- hdl/lsmc_tick_logic.sv -----
// ----------------------------------------------------------------------------
// lsmc_tick_logic
// Next-state and result logic for one tick: command latch, switch edges,
// timeout, then action on the pending request.
// ----------------------------------------------------------------------------
module lsmc_tick_logic #(
    parameter int COUNT_WIDTH = lsmc_pkg::COUNT_WIDTH_DEF
) (
    input  lsmc_pkg::ctrl_state_t              state,
    input  logic [COUNT_WIDTH-1:0]             elapsed,
    input  logic [lsmc_pkg::LIMIT_WIDTH-1:0]   run_limit,
    input  logic                               top_switch,
    input  logic                               bottom_switch,
    input  logic                               cmd_valid,
    input  logic [1:0]                         cmd_dir,
    output lsmc_pkg::ctrl_state_t              state_next,
    output logic [COUNT_WIDTH-1:0]             elapsed_next,
    output lsmc_pkg::result_t                  result
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > lsmc_pkg::LIMIT_WIDTH) ?
                               COUNT_WIDTH : lsmc_pkg::LIMIT_WIDTH;

    always_comb
    begin
        lsmc_pkg::ctrl_state_t   s;
        logic [COUNT_WIDTH-1:0]  el;
        lsmc_pkg::cause_t        cause;
        lsmc_pkg::refuse_t       refused;
        logic                    status;
        logic                    done;

        s       = state;
        el      = elapsed;
        cause   = lsmc_pkg::CAUSE_NONE;
        refused = lsmc_pkg::REFUSE_NONE;
        status  = 1'b0;
        done    = 1'b0;

        // code 3 is not a direction and leaves the request alone
        if (cmd_valid && (cmd_dir inside {lsmc_pkg::MODE_IDLE, lsmc_pkg::MODE_FWD,
                                          lsmc_pkg::MODE_REV}))
        begin
            s.pending_request = lsmc_pkg::mode_t'(cmd_dir);
        end

        if (top_switch != s.top_seen)
        begin
            s.top_seen = top_switch;
            status     = 1'b1;
            if (top_switch && s.run_state == lsmc_pkg::MODE_FWD)
            begin
                s.run_state       = lsmc_pkg::MODE_IDLE;
                s.pending_request = lsmc_pkg::MODE_IDLE;
                s.timing_on       = 1'b0;
                el                = '0;
                cause             = lsmc_pkg::CAUSE_TOP;
            end
        end

        if (bottom_switch != s.bottom_seen)
        begin
            s.bottom_seen = bottom_switch;
            status        = 1'b1;
            if (bottom_switch && s.run_state == lsmc_pkg::MODE_REV)
            begin
                s.run_state       = lsmc_pkg::MODE_IDLE;
                s.pending_request = lsmc_pkg::MODE_IDLE;
                s.timing_on       = 1'b0;
                el                = '0;
                cause             = lsmc_pkg::CAUSE_BOTTOM;
            end
        end

        if (s.timing_on && s.run_state != lsmc_pkg::MODE_IDLE)
        begin
            if (el != {COUNT_WIDTH{1'b1}})
            begin
                el = el + 1'b1;
            end
            if (CMP_WIDTH'(el) >= CMP_WIDTH'(run_limit))
            begin
                s.run_state       = lsmc_pkg::MODE_IDLE;
                s.pending_request = lsmc_pkg::MODE_IDLE;
                s.timing_on       = 1'b0;
                el                = '0;
                cause             = lsmc_pkg::CAUSE_TIMEOUT;
                status            = 1'b1;
                done              = 1'b1;
            end
        end

        if (!done && s.pending_request != s.run_state)
        begin
            status = 1'b1;
            if (s.pending_request == lsmc_pkg::MODE_FWD && s.top_seen)
            begin
                s.pending_request = lsmc_pkg::MODE_IDLE;
                refused           = lsmc_pkg::REFUSE_TOP;
            end
            else if (s.pending_request == lsmc_pkg::MODE_REV && s.bottom_seen)
            begin
                s.pending_request = lsmc_pkg::MODE_IDLE;
                refused           = lsmc_pkg::REFUSE_BOTTOM;
            end
            else
            begin
                s.run_state = s.pending_request;
                el          = '0;
                if (s.run_state == lsmc_pkg::MODE_IDLE)
                begin
                    s.timing_on = 1'b0;
                    cause       = lsmc_pkg::CAUSE_CMD;
                end
                else
                begin
                    s.timing_on = 1'b1;
                end
            end
        end

        state_next            = s;
        elapsed_next          = el;
        result.drive_a        = (s.run_state == lsmc_pkg::MODE_FWD);
        result.drive_b        = (s.run_state == lsmc_pkg::MODE_REV);
        result.motor_mode     = s.run_state;
        result.top_active     = s.top_seen;
        result.bottom_active  = s.bottom_seen;
        result.indicator_led  = top_switch | bottom_switch;
        result.stop_cause     = cause;
        result.refused        = refused;
        result.status_update  = status;
    end

endmodule

// ----- hdl/lsmc_result_reg.sv -----
// ----------------------------------------------------------------------------
// lsmc_result_reg
// Output register for result words; takes a new word whenever the held one
// leaves or none is held.
// ----------------------------------------------------------------------------
module lsmc_result_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  lsmc_pkg::result_t  load_data,
    output logic               can_load,
    lsmc_result_if.source      result
);

    logic              valid_reg;
    lsmc_pkg::result_t data_reg;

    assign can_load = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= load_data;
        end
    end

    assign result.valid         = valid_reg;
    assign result.drive_a       = data_reg.drive_a;
    assign result.drive_b       = data_reg.drive_b;
    assign result.motor_mode    = data_reg.motor_mode;
    assign result.top_active    = data_reg.top_active;
    assign result.bottom_active = data_reg.bottom_active;
    assign result.indicator_led = data_reg.indicator_led;
    assign result.stop_cause    = data_reg.stop_cause;
    assign result.refused       = data_reg.refused;
    assign result.status_update = data_reg.status_update;

endmodule

// ----- hdl/limit_switch_motor_controller.sv -----
// ----------------------------------------------------------------------------
// limit_switch_motor_controller
// H-bridge door motor control driven by millisecond tick words.
//
// Usage:
//   tick   : one word per millisecond tick with both switch samples and an
//            optional direction command.
//   result : one word per tick with the H-bridge drives, motor mode, switch
//            records, stop cause, refusal code and status flag.
//   run_limit_we / run_limit_data : write the run timeout in ticks; write
//            only while no tick is in flight.
// Results are registered: a word shows in the cycle after its tick is taken.
// Throughput is one tick per cycle while result is not stalled; the single state
// update per tick and the one-entry output register set that figure.
// When result is stalled the output register holds its word and tick.ready
// drops until it is taken; no state changes meanwhile.
// Reset leaves the motor idle, switch records clear, timer off and the run
// limit at 6000 ticks.
// ----------------------------------------------------------------------------
module limit_switch_motor_controller #(
    parameter int COUNT_WIDTH = lsmc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lsmc_tick_if.sink                        tick,
    lsmc_result_if.source                    result,
    input  logic                             run_limit_we,
    input  logic [lsmc_pkg::LIMIT_WIDTH-1:0] run_limit_data
);

    lsmc_pkg::ctrl_state_t                state_reg;
    lsmc_pkg::ctrl_state_t                state_next;
    logic [COUNT_WIDTH-1:0]               elapsed_reg;
    logic [COUNT_WIDTH-1:0]               elapsed_next;
    logic [lsmc_pkg::LIMIT_WIDTH-1:0]     run_limit_reg;
    lsmc_pkg::result_t                    step_result;
    logic                                 can_load;
    logic                                 accept;

    assign tick.ready = can_load;
    assign accept     = tick.valid && can_load;

    lsmc_tick_logic #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tick_logic (
        .state         (state_reg),
        .elapsed       (elapsed_reg),
        .run_limit     (run_limit_reg),
        .top_switch    (tick.top_switch),
        .bottom_switch (tick.bottom_switch),
        .cmd_valid     (tick.cmd_valid),
        .cmd_dir       (tick.cmd_dir),
        .state_next    (state_next),
        .elapsed_next  (elapsed_next),
        .result        (step_result)
    );

    lsmc_result_reg u_result_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (tick.valid),
        .load_data (step_result),
        .can_load  (can_load),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.run_state       <= lsmc_pkg::MODE_IDLE;
            state_reg.pending_request <= lsmc_pkg::MODE_IDLE;
            state_reg.top_seen        <= 1'b0;
            state_reg.bottom_seen     <= 1'b0;
            state_reg.timing_on       <= 1'b0;
            elapsed_reg               <= '0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_limit_reg <= lsmc_pkg::RUN_LIMIT_RESET;
        end
        else if (run_limit_we)
        begin
            run_limit_reg <= run_limit_data;
        end
    end

`ifndef SYNTHESIS
    // timer runs exactly while the motor runs
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.timing_on == (state_reg.run_state != lsmc_pkg::MODE_IDLE))
        else $error("timer flag out of step with run state");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.drive_a && result.drive_b))
        else $error("both bridge inputs driven");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.stop_cause != lsmc_pkg::CAUSE_NONE)
            |-> (result.motor_mode == lsmc_pkg::MODE_IDLE && result.status_update))
        else $error("stop reported with motor still running");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.refused != lsmc_pkg::REFUSE_NONE)
            |-> result.status_update)
        else $error("refusal without status update");

    // an accepted tick always leaves a word in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted tick produced no result word");
`endif

endmodule
